// ----- sv/blm_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// blm_pkg
// Shared types and constants for the block I/O latency monitor.
// ---------------------------------------------------------------------------
package blm_pkg;

	localparam int INFLIGHT_SLOTS_DEF = 64;
	localparam int DEVICE_SLOTS_DEF   = 256;
	localparam int HIST_BUCKETS       = 64;
	localparam int HB_W               = 6;
	localparam int QDEPTH             = 2;
	localparam int QCNT_W             = $clog2(QDEPTH + 1);
	localparam logic [7:0] WRITE_CHAR = 8'h57;
	localparam logic       CMD_ISSUE    = 1'b0;
	localparam logic       CMD_COMPLETE = 1'b1;

	typedef struct packed {
		logic        cmd;
		logic [63:0] ts;
		logic [63:0] sec;
		logic [15:0] dev;
		logic        wr;
	} item_t;

	typedef struct packed {
		logic [63:0] reads;
		logic [63:0] writes;
		logic [63:0] comps;
		logic [63:0] lsum;
		logic [31:0] depth;
	} dev_stats_t;

	typedef struct packed {
		logic            matched;
		logic            inflight_dropped;
		logic            device_table_full;
		logic            device_found;
		logic [63:0]     latency;
		logic [HB_W-1:0] bucket;
		logic [63:0]     bucket_count;
		dev_stats_t      stats;
	} result_t;

	typedef struct packed {
		logic [QCNT_W-1:0] count;
	} fq_status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SREAD,
		ST_SCMP,
		ST_SUPD,
		ST_LOG,
		ST_DREAD,
		ST_DCMP,
		ST_HREAD,
		ST_HUPD,
		ST_DUPD
	} eng_state_t;

endpackage
`default_nettype wire

// ----- sv/blm_ram.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// blm_ram
// Generic single write port RAM with one registered read port.
// ---------------------------------------------------------------------------
module blm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ----- sv/blm_front.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// blm_front
// Accepts events, classifies device and operation, and queues them.
// ---------------------------------------------------------------------------
module blm_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic                command,
	input  wire logic [63:0]         timestamp_ns,
	input  wire logic [63:0]         sector,
	input  wire logic [31:0]         device_number,
	input  wire logic [7:0]          op_char,
	output logic                     q_valid,
	output blm_pkg::item_t           q_item,
	input  wire logic                q_pop,
	output blm_pkg::fq_status_t      q_stat
);
	import blm_pkg::*;

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

	item_t             entry_q [QDEPTH];
	logic [PW-1:0]     wptr_q, rptr_q;
	logic [QCNT_W-1:0] count_q;
	item_t             in_item;
	logic              push, pop;

	always_comb begin
		in_item.cmd = command;
		in_item.ts  = timestamp_ns;
		in_item.sec = sector;
		in_item.dev = device_number[15:0];
		in_item.wr  = (op_char == WRITE_CHAR);
	end

	assign in_ready     = (count_q < QCNT_W'(QDEPTH));
	assign push         = in_valid && in_ready;
	assign pop          = q_pop && q_valid;
	assign q_valid      = (count_q != '0);
	assign q_item       = entry_q[rptr_q];
	assign q_stat.count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PW'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == PW'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q] <= in_item;
		end
	end
endmodule
`default_nettype wire

// ----- sv/blm_back.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// blm_back
// Sequential engine: sector scan, log2 bucket, device scan, updates.
// ---------------------------------------------------------------------------
module blm_back #(
	parameter int INFLIGHT_SLOTS = blm_pkg::INFLIGHT_SLOTS_DEF,
	parameter int DEVICE_SLOTS   = blm_pkg::DEVICE_SLOTS_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            q_valid,
	input  wire blm_pkg::item_t  q_item,
	output logic                 q_pop,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output blm_pkg::result_t     res
);
	import blm_pkg::*;

	localparam int SW = (INFLIGHT_SLOTS > 1) ? $clog2(INFLIGHT_SLOTS) : 1;
	localparam int DW = (DEVICE_SLOTS > 1) ? $clog2(DEVICE_SLOTS) : 1;
	localparam int SSW = $bits(dev_stats_t);

	eng_state_t state_q, state_d;

	logic [INFLIGHT_SLOTS-1:0] iv_q;
	logic [DEVICE_SLOTS-1:0]   dv_q;
	logic [HIST_BUCKETS-1:0]   hv_q;
	logic                      out_valid_q;

	item_t            it_q;
	logic [SW-1:0]    scnt_q;
	logic [DW-1:0]    dcnt_q;
	logic             shit_q, dhit_q, drop_q;
	logic [63:0]      start_q, lat_q, sh_q, bcount_q;
	logic [63:0]      bcount_d;
	logic [HB_W-1:0]  bidx_q;
	dev_stats_t       dstats_q;
	result_t          res_q, res_d;

	logic [63:0]      sec_rdata, start_rdata, h_rdata;
	logic [15:0]      id_rdata;
	logic [SSW-1:0]   stats_rdata;
	logic             sec_we, start_we, id_we, stats_we, hist_we;
	logic [SW-1:0]    s_waddr, sfree_idx;
	logic [DW-1:0]    d_waddr, dfree_idx;
	logic             sfree_any, dfree_any;
	logic             s_match, d_match, s_last, d_last, log_done, out_load;
	dev_stats_t       new_stats;
	logic             dev_write_ok;

	// lowest free slots
	always_comb begin
		sfree_any = 1'b0;
		sfree_idx = '0;
		for (int i = INFLIGHT_SLOTS - 1; i >= 0; i--) begin
			if (!iv_q[i]) begin
				sfree_any = 1'b1;
				sfree_idx = SW'(i);
			end
		end
	end

	always_comb begin
		dfree_any = 1'b0;
		dfree_idx = '0;
		for (int i = DEVICE_SLOTS - 1; i >= 0; i--) begin
			if (!dv_q[i]) begin
				dfree_any = 1'b1;
				dfree_idx = DW'(i);
			end
		end
	end

	assign s_match  = iv_q[scnt_q] && (sec_rdata == it_q.sec);
	assign d_match  = dv_q[dcnt_q] && (id_rdata == it_q.dev);
	assign s_last   = (scnt_q == SW'(INFLIGHT_SLOTS - 1));
	assign d_last   = (dcnt_q == DW'(DEVICE_SLOTS - 1));
	assign log_done = sh_q[63] || (bidx_q == '0);
	assign bcount_d = (hv_q[bidx_q] ? h_rdata : 64'd0) + 64'd1;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (q_valid) state_d = ST_SREAD;
			ST_SREAD: state_d = ST_SCMP;
			ST_SCMP:  state_d = (s_match || s_last) ? ST_SUPD : ST_SREAD;
			ST_SUPD: begin
				if (it_q.cmd == CMD_ISSUE) begin
					state_d = ST_DREAD;
				end else begin
					state_d = shit_q ? ST_LOG : ST_DUPD;
				end
			end
			ST_LOG:   if (log_done) state_d = ST_DREAD;
			ST_DREAD: state_d = ST_DCMP;
			ST_DCMP: begin
				if (d_match || d_last) begin
					state_d = (it_q.cmd == CMD_COMPLETE) ? ST_HREAD : ST_DUPD;
				end else begin
					state_d = ST_DREAD;
				end
			end
			ST_HREAD: state_d = ST_HUPD;
			ST_HUPD:  state_d = ST_DUPD;
			ST_DUPD:  if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// new device statistics
	always_comb begin
		new_stats    = dstats_q;
		dev_write_ok = 1'b0;
		if (it_q.cmd == CMD_ISSUE) begin
			if (dhit_q) begin
				dev_write_ok    = 1'b1;
				new_stats.depth = dstats_q.depth + 1'b1;
				if (it_q.wr) begin
					new_stats.writes = dstats_q.writes + 1'b1;
				end else begin
					new_stats.reads = dstats_q.reads + 1'b1;
				end
			end else if (dfree_any) begin
				dev_write_ok     = 1'b1;
				new_stats.reads  = {63'd0, !it_q.wr};
				new_stats.writes = {63'd0, it_q.wr};
				new_stats.comps  = '0;
				new_stats.lsum   = '0;
				new_stats.depth  = 32'd1;
			end
		end else if (shit_q && dhit_q) begin
			dev_write_ok    = 1'b1;
			new_stats.comps = dstats_q.comps + 1'b1;
			new_stats.lsum  = dstats_q.lsum + lat_q;
			new_stats.depth = (dstats_q.depth != '0) ? dstats_q.depth - 1'b1 : '0;
		end
	end

	// result assembly
	always_comb begin
		res_d                  = '0;
		res_d.inflight_dropped = (it_q.cmd == CMD_ISSUE) && drop_q;
		if (it_q.cmd == CMD_COMPLETE && shit_q) begin
			res_d.matched      = 1'b1;
			res_d.latency      = lat_q;
			res_d.bucket       = bidx_q;
			res_d.bucket_count = bcount_q;
		end
		if (dev_write_ok) begin
			res_d.device_found = 1'b1;
			res_d.stats        = new_stats;
		end else if (it_q.cmd == CMD_ISSUE) begin
			res_d.device_table_full = 1'b1;
		end
	end

	// control outputs
	always_comb begin
		q_pop    = 1'b0;
		sec_we   = 1'b0;
		start_we = 1'b0;
		id_we    = 1'b0;
		stats_we = 1'b0;
		hist_we  = 1'b0;
		out_load = 1'b0;
		s_waddr  = shit_q ? scnt_q : sfree_idx;
		d_waddr  = dhit_q ? dcnt_q : dfree_idx;
		unique case (state_q)
			ST_IDLE: q_pop = q_valid;
			ST_SUPD: begin
				if (it_q.cmd == CMD_ISSUE) begin
					sec_we   = !shit_q && sfree_any;
					start_we = shit_q || sfree_any;
				end
			end
			ST_HUPD: hist_we = 1'b1;
			ST_DUPD: begin
				out_load = !out_valid_q || out_ready;
				stats_we = out_load && dev_write_ok;
				id_we    = out_load && dev_write_ok && !dhit_q;
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			iv_q        <= '0;
			dv_q        <= '0;
			hv_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (sec_we) begin
				iv_q[s_waddr] <= 1'b1;
			end
			if (state_q == ST_SUPD && it_q.cmd == CMD_COMPLETE && shit_q) begin
				iv_q[scnt_q] <= 1'b0;
			end
			if (id_we) begin
				dv_q[d_waddr] <= 1'b1;
			end
			if (hist_we) begin
				hv_q[bidx_q] <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				it_q   <= q_item;
				scnt_q <= '0;
				dcnt_q <= '0;
				shit_q <= 1'b0;
				dhit_q <= 1'b0;
				drop_q <= 1'b0;
			end
			ST_SCMP: begin
				if (s_match) begin
					shit_q  <= 1'b1;
					start_q <= start_rdata;
				end else if (!s_last) begin
					scnt_q <= scnt_q + 1'b1;
				end
			end
			ST_SUPD: begin
				drop_q <= !shit_q && !sfree_any;
				lat_q  <= it_q.ts - start_q;
				sh_q   <= it_q.ts - start_q;
				bidx_q <= HB_W'(HIST_BUCKETS - 1);
			end
			ST_LOG: begin
				if (!log_done) begin
					sh_q   <= {sh_q[62:0], 1'b0};
					bidx_q <= bidx_q - 1'b1;
				end
			end
			ST_DCMP: begin
				if (d_match) begin
					dhit_q   <= 1'b1;
					dstats_q <= dev_stats_t'(stats_rdata);
				end else if (!d_last) begin
					dcnt_q <= dcnt_q + 1'b1;
				end
			end
			ST_HUPD: bcount_q <= bcount_d;
			ST_DUPD: if (out_load) res_q <= res_d;
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;

	blm_ram #(.WIDTH(64), .DEPTH(INFLIGHT_SLOTS)) u_sec_ram (
		.clk(clk), .we(sec_we), .waddr(s_waddr), .wdata(it_q.sec),
		.raddr(scnt_q), .rdata(sec_rdata)
	);
	blm_ram #(.WIDTH(64), .DEPTH(INFLIGHT_SLOTS)) u_start_ram (
		.clk(clk), .we(start_we), .waddr(s_waddr), .wdata(it_q.ts),
		.raddr(scnt_q), .rdata(start_rdata)
	);
	blm_ram #(.WIDTH(16), .DEPTH(DEVICE_SLOTS)) u_id_ram (
		.clk(clk), .we(id_we), .waddr(d_waddr), .wdata(it_q.dev),
		.raddr(dcnt_q), .rdata(id_rdata)
	);
	blm_ram #(.WIDTH(SSW), .DEPTH(DEVICE_SLOTS)) u_stats_ram (
		.clk(clk), .we(stats_we), .waddr(d_waddr), .wdata(new_stats),
		.raddr(dcnt_q), .rdata(stats_rdata)
	);
	blm_ram #(.WIDTH(64), .DEPTH(HIST_BUCKETS)) u_hist_ram (
		.clk(clk), .we(hist_we), .waddr(bidx_q), .wdata(bcount_d),
		.raddr(bidx_q), .rdata(h_rdata)
	);
endmodule
`default_nettype wire

// ----- sv/block_io_latency_monitor_core.sv -----
`default_nettype none
// Sequence: the sector RAM is scanned one entry at a time (read, then compare).
//   An issue then scans the device RAM the same way; a matched completion first
//   finds its log2 bucket by shifting, scans the device RAM, then reads and
//   updates its histogram bucket. The result goes to the output register.
// Flow: the engine takes one item at a time; a two-entry input queue keeps taking
//   items while the engine works. Reset clears valid bits at once; no clear pass.
// ---------------------------------------------------------------------------
// block_io_latency_monitor_core
// Block I/O latency monitor: in-flight sector table, per-device statistics
// and a log2 latency histogram, behind a decoupled front queue.
// ---------------------------------------------------------------------------
module block_io_latency_monitor_core #(
	parameter int INFLIGHT_SLOTS = blm_pkg::INFLIGHT_SLOTS_DEF,
	parameter int DEVICE_SLOTS   = blm_pkg::DEVICE_SLOTS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        command,
	input  wire logic [63:0] timestamp_ns,
	input  wire logic [63:0] sector,
	input  wire logic [31:0] device_number,
	input  wire logic [7:0]  op_char,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             matched,
	output logic             inflight_dropped,
	output logic             device_table_full,
	output logic             device_found,
	output logic [63:0]      latency,
	output logic [5:0]       bucket,
	output logic [63:0]      bucket_count,
	output logic [63:0]      dev_read_count,
	output logic [63:0]      dev_write_count,
	output logic [31:0]      dev_queue_depth,
	output logic [63:0]      dev_io_count,
	output logic [63:0]      dev_latency_sum
);
	import blm_pkg::*;

	logic       q_valid, q_pop;
	item_t      q_item;
	fq_status_t q_stat;
	result_t    res;

	// front: take items, split device and op, queue them
	blm_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .timestamp_ns(timestamp_ns), .sector(sector),
		.device_number(device_number), .op_char(op_char),
		.q_valid(q_valid), .q_item(q_item), .q_pop(q_pop), .q_stat(q_stat)
	);

	// back: scan tables, update stats, hold result in output register
	blm_back #(
		.INFLIGHT_SLOTS(INFLIGHT_SLOTS),
		.DEVICE_SLOTS(DEVICE_SLOTS)
	) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
		.out_valid(out_valid), .out_ready(out_ready), .res(res)
	);

	// unpack result fields
	assign matched           = res.matched;
	assign inflight_dropped  = res.inflight_dropped;
	assign device_table_full = res.device_table_full;
	assign device_found      = res.device_found;
	assign latency           = res.latency;
	assign bucket            = res.bucket;
	assign bucket_count      = res.bucket_count;
	assign dev_read_count    = res.stats.reads;
	assign dev_write_count   = res.stats.writes;
	assign dev_queue_depth   = res.stats.depth;
	assign dev_io_count      = res.stats.comps;
	assign dev_latency_sum   = res.stats.lsum;

`ifndef SYNTHESIS
	a_q_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.count <= QCNT_W'(QDEPTH))
		else $error("front queue overflow");

	a_q_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (q_stat.count != QCNT_W'(QDEPTH)))
		else $error("ready does not track queue space");

	a_unmatched_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !matched |-> latency == '0 && bucket == '0 && bucket_count == '0)
		else $error("latency fields set without a match");

	a_full_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && device_table_full |-> !device_found && !matched)
		else $error("table full together with found device");
`endif
endmodule
`default_nettype wire

// ----- sim/block_io_latency_monitor_core_test.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// block_io_latency_monitor_core_test
// Drives issue and completion items into the latency monitor and checks every
// result against a model of the sector table, device statistics and histogram.
// ---------------------------------------------------------------------------

// Latency bookkeeping: holds the in-flight table, device table and histogram
// as the block should see them, plus the results still owed by the block.
class latency_book;
	typedef struct {
		logic        matched;
		logic        inflight_dropped;
		logic        device_table_full;
		logic        device_found;
		logic [63:0] latency;
		logic [5:0]  bucket;
		logic [63:0] bucket_count;
		logic [63:0] reads;
		logic [63:0] writes;
		logic [31:0] depth;
		logic [63:0] comps;
		logic [63:0] lsum;
	} event_result_t;

	bit          sec_used[64];
	logic [63:0] sec_key[64];
	logic [63:0] sec_start[64];
	bit          dev_used[256];
	logic [15:0] dev_key[256];
	logic [63:0] dev_reads[256];
	logic [63:0] dev_writes[256];
	logic [63:0] dev_comps[256];
	logic [63:0] dev_lsum[256];
	logic [31:0] dev_depth[256];
	logic [63:0] hist[64];
	event_result_t owed_results[$];
	int          errors;

	function new();
		foreach (sec_used[i]) sec_used[i] = 0;
		foreach (dev_used[i]) dev_used[i] = 0;
		foreach (hist[i]) hist[i] = '0;
		errors = 0;
	endfunction

	function int pending();
		return owed_results.size();
	endfunction

	function int find_sec(logic [63:0] s);
		for (int i = 0; i < 64; i++)
			if (sec_used[i] && sec_key[i] == s)
				return i;
		return -1;
	endfunction

	function int find_dev(logic [15:0] d);
		for (int i = 0; i < 256; i++)
			if (dev_used[i] && dev_key[i] == d)
				return i;
		return -1;
	endfunction

	function void put_dev(ref event_result_t r, input int d);
		r.device_found = 1;
		r.reads  = dev_reads[d];
		r.writes = dev_writes[d];
		r.depth  = dev_depth[d];
		r.comps  = dev_comps[d];
		r.lsum   = dev_lsum[d];
	endfunction

	// Advance the model by one accepted item and queue its result.
	function void note_item(logic cmd, logic [63:0] ts, logic [63:0] sec,
			logic [31:0] devnum, logic [7:0] op);
		event_result_t r;
		int s, d;
		logic [15:0] dev;
		logic        wr;
		logic [63:0] lat;
		logic [5:0]  b;
		r = '{default: '0};
		dev = devnum[15:0];
		wr = (op == blm_pkg::WRITE_CHAR);
		if (cmd == blm_pkg::CMD_ISSUE) begin
			s = find_sec(sec);
			if (s < 0) begin
				for (int i = 0; i < 64 && s < 0; i++)
					if (!sec_used[i])
						s = i;
				if (s >= 0) begin
					sec_used[s] = 1;
					sec_key[s] = sec;
				end
			end
			if (s >= 0)
				sec_start[s] = ts;
			else
				r.inflight_dropped = 1;
			d = find_dev(dev);
			if (d >= 0) begin
				dev_depth[d] += 1;
				if (wr)
					dev_writes[d] += 1;
				else
					dev_reads[d] += 1;
			end else begin
				for (int i = 0; i < 256 && d < 0; i++)
					if (!dev_used[i])
						d = i;
				if (d >= 0) begin
					dev_used[d] = 1;
					dev_key[d] = dev;
					dev_reads[d] = wr ? 0 : 1;
					dev_writes[d] = wr ? 1 : 0;
					dev_comps[d] = 0;
					dev_lsum[d] = 0;
					dev_depth[d] = 1;
				end else begin
					r.device_table_full = 1;
				end
			end
			if (d >= 0)
				put_dev(r, d);
		end else begin
			s = find_sec(sec);
			if (s >= 0) begin
				lat = ts - sec_start[s];
				b = 0;
				for (int i = 1; i < 64; i++)
					if (lat[i])
						b = i;
				sec_used[s] = 0;
				d = find_dev(dev);
				if (d >= 0) begin
					dev_comps[d] += 1;
					dev_lsum[d] += lat;
					if (dev_depth[d] != 0)
						dev_depth[d] -= 1;
					put_dev(r, d);
				end
				hist[b] += 1;
				r.matched = 1;
				r.latency = lat;
				r.bucket = b;
				r.bucket_count = hist[b];
			end
		end
		owed_results.push_back(r);
	endfunction

	function void cmp(string name, logic [63:0] e, logic [63:0] a);
		if (e !== a) begin
			errors++;
			if (errors <= 10)
				$display("mismatch %s: expected %h actual %h", name, e, a);
		end
	endfunction

	// Check one accepted result against the oldest owed result.
	function void check_result(blm_pkg::result_t a);
		event_result_t e;
		if (owed_results.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("mismatch: result with no item outstanding");
			return;
		end
		e = owed_results.pop_front();
		cmp("matched", e.matched, a.matched);
		cmp("inflight_dropped", e.inflight_dropped, a.inflight_dropped);
		cmp("device_table_full", e.device_table_full, a.device_table_full);
		cmp("device_found", e.device_found, a.device_found);
		cmp("latency", e.latency, a.latency);
		cmp("bucket", e.bucket, a.bucket);
		cmp("bucket_count", e.bucket_count, a.bucket_count);
		cmp("dev_read_count", e.reads, a.stats.reads);
		cmp("dev_write_count", e.writes, a.stats.writes);
		cmp("dev_queue_depth", e.depth, a.stats.depth);
		cmp("dev_io_count", e.comps, a.stats.comps);
		cmp("dev_latency_sum", e.lsum, a.stats.lsum);
	endfunction
endclass

module block_io_latency_monitor_core_test;
	import blm_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        command;
	logic [63:0] timestamp_ns;
	logic [63:0] sector;
	logic [31:0] device_number;
	logic [7:0]  op_char;
	logic        out_valid;
	logic        out_ready;
	logic        matched;
	logic        inflight_dropped;
	logic        device_table_full;
	logic        device_found;
	logic [63:0] latency;
	logic [5:0]  bucket;
	logic [63:0] bucket_count;
	logic [63:0] dev_read_count;
	logic [63:0] dev_write_count;
	logic [31:0] dev_queue_depth;
	logic [63:0] dev_io_count;
	logic [63:0] dev_latency_sum;

	latency_book book;
	int          hold_off_cycles;   // long receiver hold requested by stimulus
	bit          quiet_sender;      // stretch with no sender gaps
	logic [63:0] sector_pool[100];
	logic [15:0] dev_pool[8];
	logic [63:0] clock_ns;

	block_io_latency_monitor_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .timestamp_ns(timestamp_ns), .sector(sector),
		.device_number(device_number), .op_char(op_char),
		.out_valid(out_valid), .out_ready(out_ready),
		.matched(matched), .inflight_dropped(inflight_dropped),
		.device_table_full(device_table_full), .device_found(device_found),
		.latency(latency), .bucket(bucket), .bucket_count(bucket_count),
		.dev_read_count(dev_read_count), .dev_write_count(dev_write_count),
		.dev_queue_depth(dev_queue_depth), .dev_io_count(dev_io_count),
		.dev_latency_sum(dev_latency_sum)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Gap length: mostly short, now and then long.
	function int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 60)
			return 0;
		if (p < 90)
			return $urandom_range(1, 3);
		if (p < 97)
			return $urandom_range(4, 20);
		return $urandom_range(50, 400);
	endfunction

	// Offer one item, hold it until accepted, then note it in the book.
	task automatic send_item(logic cmd, logic [63:0] ts, logic [63:0] sec,
			logic [31:0] devnum, logic [7:0] op);
		int g;
		@(negedge clk);
		command = cmd;
		timestamp_ns = ts;
		sector = sec;
		device_number = devnum;
		op_char = op;
		in_valid = 1;
		do
			@(posedge clk);
		while (!in_ready);
		book.note_item(cmd, ts, sec, devnum, op);
		g = quiet_sender ? 0 : gap_len();
		if (g > 0) begin
			@(negedge clk);
			in_valid = 0;
			repeat (g - 1) @(negedge clk);
		end
	endtask

	// Receiver: check at the rising edge, change ready at the falling edge.
	initial begin : receiver
		int stall;
		blm_pkg::result_t r;
		stall = 0;
		out_ready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				r.matched = matched;
				r.inflight_dropped = inflight_dropped;
				r.device_table_full = device_table_full;
				r.device_found = device_found;
				r.latency = latency;
				r.bucket = bucket;
				r.bucket_count = bucket_count;
				r.stats.reads = dev_read_count;
				r.stats.writes = dev_write_count;
				r.stats.comps = dev_io_count;
				r.stats.lsum = dev_latency_sum;
				r.stats.depth = dev_queue_depth;
				book.check_result(r);
			end
			@(negedge clk);
			if (hold_off_cycles > 0) begin
				// long hold: let the input queue fill and stall the sender
				hold_off_cycles--;
				out_ready = 0;
			end else if (stall > 0) begin
				stall--;
				out_ready = 0;
			end else begin
				out_ready = 1;
				if ($urandom_range(0, 7) == 0)
					stall = gap_len();
			end
		end
	end

	// Random item: mostly pooled sectors and devices so that completions
	// match, tables fill and counts build up; the rest is fresh noise.
	task automatic send_random();
		logic        cmd;
		logic [63:0] sec;
		logic [31:0] devnum;
		logic [7:0]  op;
		int          p;
		cmd = ($urandom_range(0, 99) < 55) ? CMD_ISSUE : CMD_COMPLETE;
		sec = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
			: sector_pool[$urandom_range(0, 99)];
		devnum = $urandom;
		if ($urandom_range(0, 3) != 0)
			devnum[15:0] = dev_pool[$urandom_range(0, 7)];
		op = $urandom_range(0, 1) ? WRITE_CHAR : 8'($urandom);
		p = $urandom_range(0, 9);
		// advance time by a spread of magnitudes; now and then jump anywhere
		if (p == 0)
			clock_ns = {$urandom, $urandom};
		else
			clock_ns += 64'($urandom) >> $urandom_range(0, 31);
		send_item(cmd, clock_ns, sec, devnum, op);
	endtask

	initial begin : limit
		#60_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin : stimulus
		logic [63:0] ones;
		ones = '1;
		book = new();
		hold_off_cycles = 0;
		quiet_sender = 0;
		clock_ns = 0;
		in_valid = 0;
		command = CMD_ISSUE;
		timestamp_ns = 0;
		sector = 0;
		device_number = 0;
		op_char = 0;
		arst_n = 0;
		foreach (sector_pool[i]) sector_pool[i] = {$urandom, $urandom};
		foreach (dev_pool[i]) dev_pool[i] = 16'($urandom);
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: overwrite, zero and one latency, unmatched completion
		send_item(CMD_ISSUE, 0, 0, 1, WRITE_CHAR);
		send_item(CMD_ISSUE, 100, 0, 1, 8'h00);
		send_item(CMD_COMPLETE, 100, 0, 1, 8'hFF);
		send_item(CMD_ISSUE, 5, ones, 1, 8'hFF);
		send_item(CMD_COMPLETE, 6, ones, 1, 8'h00);
		send_item(CMD_COMPLETE, 7, ones, 1, 8'h00);
		// timestamp wrap and extreme device number
		send_item(CMD_ISSUE, ones, 64'h5, 32'hFFFF_FFFF, WRITE_CHAR);
		send_item(CMD_COMPLETE, 64'h5, 64'h5, 32'hFFFF_FFFF, 8'h52);
		// highest bucket
		send_item(CMD_ISSUE, 0, 64'h6, 32'h0001_0000, 8'h52);
		send_item(CMD_COMPLETE, ones, 64'h6, 32'h0001_0000, 8'h52);
		// completion for a device never seen
		send_item(CMD_ISSUE, 10, 64'h7, 2, WRITE_CHAR);
		send_item(CMD_COMPLETE, 20, 64'h7, 3, WRITE_CHAR);
		// queue depth held at zero
		send_item(CMD_ISSUE, 30, 64'h8, 5, 8'h00);
		send_item(CMD_COMPLETE, 40, 64'h8, 5, 8'h00);
		send_item(CMD_ISSUE, 50, 64'h9, 6, 8'h00);
		send_item(CMD_COMPLETE, 1050, 64'h9, 5, 8'h00);
		send_item(CMD_COMPLETE, 1050, 64'h9, 6, 8'h00);
		send_item(CMD_ISSUE, 64'h8000_0000_0000_0000, 64'hA, 32'hAAAA_5555,
			8'h56);
		send_item(CMD_COMPLETE, 64'h8000_0000_0000_0400, 64'hA, 32'h5555_AAAA,
			8'h58);

		for (int n = 0; n < 1200; n++) begin
			if (n % 100 == 0)
				quiet_sender = ($urandom_range(0, 3) == 0);
			if (n == 300)
				hold_off_cycles = 4000;
			if (n == 600) begin
				// drain pause: drop valid, then wait for every owed result
				@(negedge clk);
				in_valid = 0;
				while (book.pending() != 0)
					@(posedge clk);
			end
			send_random();
		end

		@(negedge clk);
		in_valid = 0;
		while (book.pending() != 0)
			@(posedge clk);
		repeat (2000) @(posedge clk);
		if (book.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
